[design/ptr_pkg.sv]
`default_nettype none
// Package: item kinds, bit masks and result type for the paper tape reader interface.
package ptr_pkg;

  localparam int WORD_W  = 36;
  localparam int LEVEL_W = 3;
  localparam int BUS_W   = 6;
  localparam int FRAME_W = 8;
  localparam int MARKS_W = 6;
  localparam int FIELD_W = 6;

  typedef enum logic [2:0] {
    KIND_CLEAR  = 3'd0,
    KIND_CTRL   = 3'd1,
    KIND_STATUS = 3'd2,
    KIND_DATA   = 3'd3,
    KIND_FRAME  = 3'd4,
    KIND_EOT    = 3'd5,
    KIND_MOTOR  = 3'd6
  } kind_t;

  // control-set bus bits
  localparam int CTRL_BINARY = 5;
  localparam int CTRL_BUSY   = 4;
  localparam int CTRL_FLAG   = 3;

  // tape frame masks
  localparam logic [FRAME_W-1:0] BIN_PUNCH  = 8'o200;
  localparam logic [FRAME_W-1:0] FIELD_MASK = 8'o077;
  localparam logic [FRAME_W-1:0] HIGH_MASK  = 8'o300;
  localparam logic [MARKS_W-1:0] LAST_MARK  = 6'o40;

  typedef struct packed {
    logic [WORD_W-1:0]  bus_out;
    logic [LEVEL_W-1:0] request_level;
    logic               busy_now;
    logic               flag_now;
  } result_t;

endpackage
`default_nettype wire

[design/ptr_item_if.sv]
`default_nettype none
// Interface: input item channel (valid/ready plus item fields).
interface ptr_item_if;
  import ptr_pkg::*;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic [BUS_W-1:0]   bus_in;
  logic [FRAME_W-1:0] frame;
  logic               motor_request;

  modport source (output valid, kind, bus_in, frame, motor_request, input ready);
  modport sink (input valid, kind, bus_in, frame, motor_request, output ready);
endinterface
`default_nettype wire

[design/ptr_result_if.sv]
`default_nettype none
// Interface: result channel (valid/ready plus result fields).
interface ptr_result_if;
  import ptr_pkg::*;
  logic               valid;
  logic               ready;
  logic [WORD_W-1:0]  bus_out;
  logic [LEVEL_W-1:0] request_level;
  logic               busy_now;
  logic               flag_now;

  modport source (output valid, bus_out, request_level, busy_now, flag_now, input ready);
  modport sink (input valid, bus_out, request_level, busy_now, flag_now, output ready);
endinterface
`default_nettype wire

[design/ptr_core.sv]
`default_nettype none
// Reader state registers and the single-pass update for one accepted beat.
module ptr_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        accept,
  input  wire logic [2:0]                  kind,
  input  wire logic [ptr_pkg::BUS_W-1:0]   bus_in,
  input  wire logic [ptr_pkg::FRAME_W-1:0] frame,
  input  wire logic                        motor_request,
  output ptr_pkg::result_t                 result
);
  import ptr_pkg::*;

  logic                binary_mode, binary_mode_next;
  logic                busy_bit, busy_bit_next;
  logic                done_flag, done_flag_next;
  logic [LEVEL_W-1:0]  int_level, int_level_next;
  logic                motor_running, motor_running_next;
  logic [MARKS_W-1:0]  frame_marks, frame_marks_next;
  logic [WORD_W-1:0]   data_word, data_word_next;
  logic                in_word, in_word_next;

  logic [MARKS_W-1:0]  marks_base;
  logic [WORD_W-1:0]   word_base;
  logic [WORD_W-1:0]   high_bits;
  logic                use_frame;
  logic [WORD_W-1:0]   bus_out;

  always_comb begin
    marks_base = in_word ? frame_marks : '0;
    word_base  = in_word ? data_word : '0;
    use_frame  = !binary_mode || ((frame & BIN_PUNCH) != '0);
    high_bits  = binary_mode ? '0 : {{(WORD_W-FRAME_W){1'b0}}, frame & HIGH_MASK};
  end

  always_comb begin
    binary_mode_next   = binary_mode;
    busy_bit_next      = busy_bit;
    done_flag_next     = done_flag;
    int_level_next     = int_level;
    motor_running_next = motor_running;
    frame_marks_next   = frame_marks;
    data_word_next     = data_word;
    in_word_next       = in_word;
    bus_out            = '0;
    unique case (kind_t'(kind))
      KIND_CLEAR: begin
        int_level_next   = '0;
        busy_bit_next    = 1'b0;
        done_flag_next   = 1'b0;
        binary_mode_next = 1'b0;
      end
      KIND_CTRL: begin
        binary_mode_next = binary_mode | bus_in[CTRL_BINARY];
        busy_bit_next    = busy_bit | bus_in[CTRL_BUSY];
        done_flag_next   = done_flag | bus_in[CTRL_FLAG];
        int_level_next   = int_level | bus_in[LEVEL_W-1:0];
      end
      KIND_STATUS: begin
        bus_out = {{(WORD_W-9){1'b0}}, motor_running, 2'b00,
                   binary_mode, busy_bit, done_flag, int_level};
      end
      KIND_DATA: begin
        bus_out        = data_word;
        done_flag_next = 1'b0;
        busy_bit_next  = 1'b1;
      end
      KIND_FRAME: begin
        if (busy_bit && motor_running) begin
          in_word_next = 1'b1;
          if (use_frame) begin
            frame_marks_next = {marks_base[MARKS_W-2:0], 1'b1};
            data_word_next   = {word_base[WORD_W-FIELD_W-1:0], frame[FIELD_W-1:0]}
                               | high_bits;
          end else begin
            frame_marks_next = marks_base;
            data_word_next   = word_base;
          end
          if (!binary_mode || ((frame_marks_next & LAST_MARK) != '0)) begin
            busy_bit_next  = 1'b0;
            done_flag_next = 1'b1;
            in_word_next   = 1'b0;
          end
        end
      end
      KIND_EOT: begin
        if (busy_bit && motor_running) begin
          busy_bit_next = 1'b0;
        end
      end
      KIND_MOTOR: begin
        if (motor_running != motor_request) begin
          motor_running_next = motor_request;
          if (motor_request) begin
            busy_bit_next = 1'b0;
          end
          done_flag_next = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (!busy_bit_next) begin
      in_word_next = 1'b0;
    end
  end

  always_comb begin
    result.bus_out       = bus_out;
    result.request_level = done_flag_next ? int_level_next : '0;
    result.busy_now      = busy_bit_next;
    result.flag_now      = done_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      binary_mode   <= 1'b0;
      busy_bit      <= 1'b0;
      done_flag     <= 1'b0;
      int_level     <= '0;
      motor_running <= 1'b0;
      frame_marks   <= '0;
      data_word     <= '0;
      in_word       <= 1'b0;
    end else if (accept) begin
      binary_mode   <= binary_mode_next;
      busy_bit      <= busy_bit_next;
      done_flag     <= done_flag_next;
      int_level     <= int_level_next;
      motor_running <= motor_running_next;
      frame_marks   <= frame_marks_next;
      data_word     <= data_word_next;
      in_word       <= in_word_next;
    end
  end

  // a word in progress always has busy behind it
  a_in_word_busy: assert property (@(posedge clk) disable iff (rst)
    in_word |-> busy_bit) else $error("in_word set without busy");

  a_data_read_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && kind == KIND_DATA) |=> (busy_bit && !done_flag))
    else $error("data read did not restart reader");

  a_word_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> ($stable(data_word) && $stable(busy_bit) && $stable(done_flag)))
    else $error("state changed without a beat");

endmodule
`default_nettype wire

[design/ptr_skid.sv]
`default_nettype none
// Two-entry result buffer: output register plus skid register.
module ptr_skid (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire ptr_pkg::result_t push_data,
  output logic                  push_ready,
  ptr_result_if.source          result
);
  import ptr_pkg::*;

  logic    out_valid;
  logic    skid_valid;
  result_t out_data;
  result_t skid_data;
  logic    pop;
  logic    head_free;

  assign pop        = out_valid && result.ready;
  assign head_free  = !out_valid || pop;
  assign push_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (head_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= push;
      end else begin
        out_valid  <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (head_free) begin
      if (skid_valid) begin
        out_data <= skid_data;
        if (push) begin
          skid_data <= push_data;
        end
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

  assign result.valid         = out_valid;
  assign result.bus_out       = out_data.bus_out;
  assign result.request_level = out_data.request_level;
  assign result.busy_now      = out_data.busy_now;
  assign result.flag_now      = out_data.flag_now;

  a_skid_behind_head: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid) else $error("skid full with empty head");

  a_skid_moves_up: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && result.ready) |=> out_valid)
    else $error("skid beat lost");

  a_empty_push: assert property (@(posedge clk) disable iff (rst)
    (push && !out_valid) |=> (out_valid && !skid_valid))
    else $error("push into empty buffer misplaced");

endmodule
`default_nettype wire

[design/paper_tape_reader_interface_top.sv]
`default_nettype none
// Top level: paper tape reader bus interface, one beat in, one result beat out.
//
//   channel   direction  beat contents
//   item      in         kind, bus_in, frame, motor_request
//   result    out        bus_out, request_level, busy_now, flag_now
//
// For every accepted item, state updates at the accepting edge and the result is
// written into the output buffer on that same edge.
// Two-entry output buffer; item.ready drops only when both entries hold results.
// rst is synchronous and clears all reader state and both buffer entries.
module paper_tape_reader_interface_top (
  input  wire logic    clk,
  input  wire logic    rst,
  ptr_item_if.sink     item,
  ptr_result_if.source result
);
  import ptr_pkg::*;

  logic    accept;
  logic    buf_ready;
  result_t core_result;

  assign item.ready = buf_ready;
  assign accept     = item.valid && buf_ready;

  ptr_core u_core (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .kind          (item.kind),
    .bus_in        (item.bus_in),
    .frame         (item.frame),
    .motor_request (item.motor_request),
    .result        (core_result)
  );

  ptr_skid u_skid (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_data  (core_result),
    .push_ready (buf_ready),
    .result     (result)
  );

endmodule
`default_nettype wire

[sim/ptr_reader_checker.sv]
`default_nettype none
// Checker: watches the item and result channels, predicts each reply and compares it.
module ptr_reader_checker (
  input  wire logic clk,
  input  wire logic rst,
  ptr_item_if       item_mon,
  ptr_result_if     result_mon,
  output int        mismatches,
  output int        outstanding
);
  import ptr_pkg::*;

  localparam int MOTOR_BIT    = 8;
  localparam int REPORT_LIMIT = 10;

  logic               bin_mode;
  logic               busy;
  logic               flag;
  logic               motor;
  logic               assembling;
  logic [LEVEL_W-1:0] level;
  logic [MARKS_W-1:0] marks;
  logic [WORD_W-1:0]  word;

  result_t pending_replies[$];
  result_t seen;
  result_t want;

  function automatic result_t reader_step(input kind_t k, input logic [BUS_W-1:0] bus,
                                          input logic [FRAME_W-1:0] fr, input logic mreq);
    result_t r;
    r = '0;
    case (k)
      KIND_CLEAR: begin
        level    = '0;
        busy     = 1'b0;
        flag     = 1'b0;
        bin_mode = 1'b0;
      end
      KIND_CTRL: begin
        if (bus[CTRL_BINARY]) bin_mode = 1'b1;
        if (bus[CTRL_BUSY]) busy = 1'b1;
        if (bus[CTRL_FLAG]) flag = 1'b1;
        level = level | bus[LEVEL_W-1:0];
      end
      KIND_STATUS: begin
        r.bus_out[MOTOR_BIT]     = motor;
        r.bus_out[CTRL_BINARY]   = bin_mode;
        r.bus_out[CTRL_BUSY]     = busy;
        r.bus_out[CTRL_FLAG]     = flag;
        r.bus_out[LEVEL_W-1:0]   = level;
      end
      KIND_DATA: begin
        r.bus_out = word;
        flag      = 1'b0;
        busy      = 1'b1;
      end
      KIND_FRAME: begin
        if (busy && motor) begin
          if (!assembling) begin
            marks      = '0;
            word       = '0;
            assembling = 1'b1;
          end
          if (!bin_mode || (fr & BIN_PUNCH) != '0) begin
            marks = {marks[MARKS_W-2:0], 1'b1};
            word  = {word[WORD_W-FIELD_W-1:0], fr[FIELD_W-1:0]};
            if (!bin_mode) word = word | {{(WORD_W-FRAME_W){1'b0}}, fr & HIGH_MASK};
          end
          if (!bin_mode || (marks & LAST_MARK) != '0) begin
            busy       = 1'b0;
            flag       = 1'b1;
            assembling = 1'b0;
          end
        end
      end
      KIND_EOT: begin
        if (busy && motor) busy = 1'b0;
      end
      KIND_MOTOR: begin
        if (motor != mreq) begin
          motor = mreq;
          if (motor) busy = 1'b0;
          flag = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (!busy) assembling = 1'b0;
    r.request_level = flag ? level : '0;
    r.busy_now      = busy;
    r.flag_now      = flag;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      bin_mode    = 1'b0;
      busy        = 1'b0;
      flag        = 1'b0;
      motor       = 1'b0;
      assembling  = 1'b0;
      level       = '0;
      marks       = '0;
      word        = '0;
      pending_replies.delete();
      mismatches  = 0;
      outstanding = 0;
    end else begin
      // compare before pushing: a reply never leaves on the edge that takes its item
      if (result_mon.valid && result_mon.ready) begin
        seen.bus_out       = result_mon.bus_out;
        seen.request_level = result_mon.request_level;
        seen.busy_now      = result_mon.busy_now;
        seen.flag_now      = result_mon.flag_now;
        if (pending_replies.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: result beat with none expected:", $realtime,
                     " bus_out %o level %0d busy %b flag %b",
                     seen.bus_out, seen.request_level, seen.busy_now, seen.flag_now);
        end else begin
          want = pending_replies.pop_front();
          if (seen.bus_out !== want.bus_out || seen.request_level !== want.request_level ||
              seen.busy_now !== want.busy_now || seen.flag_now !== want.flag_now) begin
            mismatches = mismatches + 1;
            if (mismatches <= REPORT_LIMIT)
              $display("%0t: mismatch: expected bus_out %o level %0d busy %b flag %b,",
                       $realtime, want.bus_out, want.request_level, want.busy_now,
                       want.flag_now,
                       " got bus_out %o level %0d busy %b flag %b",
                       seen.bus_out, seen.request_level, seen.busy_now, seen.flag_now);
          end
        end
      end
      if (item_mon.valid && item_mon.ready)
        pending_replies.push_back(reader_step(kind_t'(item_mon.kind), item_mon.bus_in,
                                              item_mon.frame, item_mon.motor_request));
      outstanding = pending_replies.size();
    end
  end

endmodule
`default_nettype wire

[sim/paper_tape_reader_interface_top_tb.sv]
`default_nettype none
// Testbench top: clock, reset, item stimulus, result back-pressure and the verdict.
module paper_tape_reader_interface_top_tb;
  import ptr_pkg::*;

  localparam int DIRECTED = 25;
  localparam int RANDOM   = 600;

  logic clk;
  logic rst;
  bit   calm;
  int   mismatches;
  int   outstanding;
  int   sent;

  ptr_item_if   item_ch ();
  ptr_result_if result_ch ();

  paper_tape_reader_interface_top dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  ptr_reader_checker reader_chk (
    .clk         (clk),
    .rst         (rst),
    .item_mon    (item_ch),
    .result_mon  (result_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      result_ch.ready <= calm || ($urandom_range(99) >= 17);
    end
  end

  // entered and left at a falling edge; valid stays high for a back-to-back beat
  task automatic send_beat(input kind_t k, input logic [BUS_W-1:0] bus,
                           input logic [FRAME_W-1:0] fr, input logic mreq);
    if (!calm)
      while ($urandom_range(99) < 17) begin
        item_ch.valid <= 1'b0;
        @(negedge clk);
      end
    item_ch.valid         <= 1'b1;
    item_ch.kind          <= k;
    item_ch.bus_in        <= bus;
    item_ch.frame         <= fr;
    item_ch.motor_request <= mreq;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    @(negedge clk);
    sent = sent + 1;
  endtask

  initial begin
    logic                 use_bin;
    logic                 broken;
    logic                 paused;
    int                   used;
    logic [FRAME_W-1:0]   fr;
    rst                   = 1'b1;
    calm                  = 1'b0;
    sent                  = 0;
    paused                = 1'b0;
    item_ch.valid         = 1'b0;
    item_ch.kind          = KIND_CLEAR;
    item_ch.bus_in        = '0;
    item_ch.frame         = '0;
    item_ch.motor_request = 1'b0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_beat(KIND_STATUS, 6'o00, 8'o000, 1'b0);
    send_beat(KIND_DATA,   6'o00, 8'o000, 1'b0);
    send_beat(KIND_CTRL,   6'o77, 8'o377, 1'b1);
    send_beat(KIND_STATUS, 6'o77, 8'o377, 1'b1);
    send_beat(KIND_CLEAR,  6'o77, 8'o377, 1'b1);
    send_beat(KIND_MOTOR,  6'o00, 8'o000, 1'b1);
    send_beat(KIND_MOTOR,  6'o00, 8'o000, 1'b1);  // no change
    send_beat(KIND_FRAME,  6'o00, 8'o377, 1'b0);  // not busy: ignored
    send_beat(KIND_CTRL,   6'o20, 8'o000, 1'b0);
    send_beat(KIND_FRAME,  6'o00, 8'o377, 1'b0);
    send_beat(KIND_DATA,   6'o00, 8'o000, 1'b0);
    send_beat(KIND_FRAME,  6'o00, 8'o000, 1'b0);
    send_beat(KIND_CTRL,   6'o63, 8'o000, 1'b0);  // binary, busy, level 3
    send_beat(KIND_FRAME,  6'o00, 8'o277, 1'b0);
    send_beat(KIND_FRAME,  6'o00, 8'o100, 1'b0);  // no punch: skipped
    send_beat(KIND_FRAME,  6'o00, 8'o200, 1'b0);
    send_beat(KIND_FRAME,  6'o00, 8'o252, 1'b0);
    send_beat(KIND_FRAME,  6'o00, 8'o325, 1'b0);
    send_beat(KIND_FRAME,  6'o00, 8'o377, 1'b0);
    send_beat(KIND_FRAME,  6'o00, 8'o201, 1'b0);
    send_beat(KIND_STATUS, 6'o00, 8'o000, 1'b0);
    send_beat(KIND_DATA,   6'o00, 8'o000, 1'b0);
    send_beat(KIND_EOT,    6'o00, 8'o000, 1'b0);
    send_beat(KIND_MOTOR,  6'o00, 8'o000, 1'b0);
    send_beat(KIND_FRAME,  6'o00, 8'o377, 1'b0);  // motor off: ignored

    while (sent < DIRECTED + RANDOM) begin
      calm = (sent >= DIRECTED + 200 && sent < DIRECTED + 320);
      if (!paused && sent >= DIRECTED + 400) begin
        paused = 1'b1;
        item_ch.valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
      end
      if ($urandom_range(99) < 65) begin
        use_bin = 1'($urandom_range(1));
        if ($urandom_range(99) < 70)
          send_beat(KIND_MOTOR, BUS_W'($urandom), FRAME_W'($urandom), 1'b1);
        if (!use_bin)
          send_beat(KIND_CLEAR, BUS_W'($urandom), FRAME_W'($urandom), 1'($urandom));
        send_beat(KIND_CTRL, {use_bin, 1'b1, 4'($urandom)}, FRAME_W'($urandom),
                  1'($urandom));
        if (use_bin) begin
          used   = 0;
          broken = 1'b0;
          while (used < 6 && !broken) begin
            fr = FRAME_W'($urandom);
            if ($urandom_range(99) < 85) fr[7] = 1'b1;
            if ($urandom_range(99) < 4) begin
              broken = 1'b1;
              send_beat(KIND_EOT, BUS_W'($urandom), fr, 1'($urandom));
            end else begin
              send_beat(KIND_FRAME, BUS_W'($urandom), fr, 1'($urandom));
              if (fr[7]) used = used + 1;
            end
          end
        end else begin
          send_beat(KIND_FRAME, BUS_W'($urandom), FRAME_W'($urandom), 1'($urandom));
        end
        if ($urandom_range(1) == 1)
          send_beat(KIND_STATUS, BUS_W'($urandom), FRAME_W'($urandom), 1'($urandom));
        send_beat(KIND_DATA, BUS_W'($urandom), FRAME_W'($urandom), 1'($urandom));
      end else begin
        send_beat(kind_t'($urandom_range(6)), BUS_W'($urandom), FRAME_W'($urandom),
                  1'($urandom));
      end
    end

    item_ch.valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
`default_nettype wire
